// ===== design/ttcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcs_pkg: shared types and constants of the text terminal engine
// field widths, mode and command codes, register indexes, reset colors
// ----------------------------------------------------------------------------
package ttcs_pkg;

  // default screen geometry
  localparam int unsigned COLUMNS_DEF   = 80;
  localparam int unsigned TEXT_ROWS_DEF = 24;

  // command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // port field widths
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned ROW_W     = 5;
  localparam int unsigned COL_W     = 7;
  localparam int unsigned ATTR_W    = 8;
  localparam int unsigned CELL_W    = CHAR_W + ATTR_W;
  localparam int unsigned CFG_IDX_W = 2;

  // mode field codes
  localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_COLOR = 2'd1;

  localparam logic [ATTR_W-1:0] TEXT_COLOR_RST   = 8'd4;
  localparam logic [ATTR_W-1:0] HEADER_COLOR_RST = 8'd64;

  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'd32;

  // classified command
  typedef enum logic [2:0] {
    CMD_PUT     = 3'd0,
    CMD_NEWLINE = 3'd1,
    CMD_READ    = 3'd2,
    CMD_CLEAR   = 3'd3,
    CMD_REPORT  = 3'd4
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } cmd_t;

endpackage

// ===== design/ttcs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcs_front: input stage of the text terminal engine
// classifies each input transfer into a command and queues it for the back end
// ----------------------------------------------------------------------------
module ttcs_front #(
  parameter int unsigned COLUMNS   = ttcs_pkg::COLUMNS_DEF,
  parameter int unsigned TEXT_ROWS = ttcs_pkg::TEXT_ROWS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [ttcs_pkg::MODE_W-1:0] mode_i,
  input  logic [ttcs_pkg::CHAR_W-1:0] char_code_i,
  input  logic [ttcs_pkg::ROW_W-1:0]  read_row_i,
  input  logic [ttcs_pkg::COL_W-1:0]  read_col_i,
  input  logic                        init_busy_i,
  output logic                        cmd_valid_o,
  input  logic                        cmd_pop_i,
  output ttcs_pkg::cmd_t              cmd_o
);
  import ttcs_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [PW:0]   CNT_FULL = (PW + 1)'(QUEUE_DEPTH);

  cmd_t          q_mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PW:0]   count_q, count_d;
  cmd_t          in_cmd;
  logic          in_range;
  logic          push, pop;

  // read of a cell off the screen reports only the cursor
  assign in_range = (32'(read_row_i) <= TEXT_ROWS) && (32'(read_col_i) < COLUMNS);

  always_comb begin
    in_cmd.ch   = char_code_i;
    in_cmd.row  = read_row_i;
    in_cmd.col  = read_col_i;
    in_cmd.kind = CMD_REPORT;
    case (mode_i)
      MODE_PUT: begin
        in_cmd.kind = (char_code_i == CHAR_NEWLINE) ? CMD_NEWLINE : CMD_PUT;
      end
      MODE_READ: begin
        if (in_range) begin
          in_cmd.kind = CMD_READ;
        end
      end
      MODE_CLEAR: begin
        in_cmd.kind = CMD_CLEAR;
      end
      default: begin
        in_cmd.kind = CMD_REPORT;
      end
    endcase
  end

  assign in_stall_o  = (count_q == CNT_FULL) || init_busy_i;
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = q_mem[rd_ptr_q];
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = cmd_valid_o && cmd_pop_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= in_cmd;
    end
  end

endmodule

// ===== design/ttcs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcs_back: execution stage of the text terminal engine
// owns the screen memory, cursor, color registers, sweeps and result register
// ----------------------------------------------------------------------------
module ttcs_back #(
  parameter int unsigned COLUMNS   = ttcs_pkg::COLUMNS_DEF,
  parameter int unsigned TEXT_ROWS = ttcs_pkg::TEXT_ROWS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  output logic                           cmd_pop_o,
  input  ttcs_pkg::cmd_t                 cmd_i,
  output logic                           init_busy_o,
  input  logic                           cfg_valid_i,
  input  logic [ttcs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ttcs_pkg::ATTR_W-1:0]    cfg_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [ttcs_pkg::CELL_W-1:0]    read_cell_o,
  output logic [ttcs_pkg::ROW_W-1:0]     cursor_row_o,
  output logic [ttcs_pkg::COL_W-1:0]     cursor_col_o,
  output logic                           scrolled_o
);
  import ttcs_pkg::*;

  localparam int unsigned CELLS = (TEXT_ROWS + 1) * COLUMNS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned RW    = $clog2(TEXT_ROWS + 1);
  localparam int unsigned CW    = $clog2(COLUMNS);

  localparam logic [AW-1:0] ROW_STEP    = AW'(COLUMNS);
  localparam logic [AW-1:0] SCROLL_SRC0 = AW'(2 * COLUMNS);
  localparam logic [AW-1:0] SCROLL_END  = AW'(TEXT_ROWS * COLUMNS);
  localparam logic [RW-1:0] ROW_FIRST   = RW'(1);
  localparam logic [RW-1:0] ROW_LAST    = RW'(TEXT_ROWS - 1);
  localparam logic [RW-1:0] ROW_STATUS  = RW'(TEXT_ROWS);
  localparam logic [CW-1:0] COL_LAST    = CW'(COLUMNS - 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CLEAR  = 4'b0010,
    ST_SCROLL = 4'b0100,
    ST_READ   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [RW-1:0]     row_q, row_d;
  logic [CW-1:0]     col_q, col_d;
  logic [ATTR_W-1:0] txt_q, hdr_q;
  logic [ATTR_W-1:0] clr_txt_q, clr_txt_d, clr_hdr_q, clr_hdr_d;
  logic              init_q, init_d;
  logic [AW-1:0]     clr_addr_q, clr_addr_d;
  logic [RW-1:0]     clr_row_q, clr_row_d;
  logic [CW-1:0]     clr_col_q, clr_col_d;
  logic [AW-1:0]     src_q, src_d, dst_q, dst_d;
  logic              pend_q, pend_d;

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rd_q;
  logic              we;
  logic [AW-1:0]     wa, ra;
  logic [CELL_W-1:0] wd;

  logic              out_valid_q, out_valid_d;
  logic [CELL_W-1:0] out_cell_q;
  logic [ROW_W-1:0]  out_row_q;
  logic [COL_W-1:0]  out_col_q;
  logic              out_scrolled_q;

  logic              out_free, next_row, emit, emit_scrolled;
  logic [CELL_W-1:0] emit_cell;
  logic [AW-1:0]     cur_addr, rd_addr;
  logic [ATTR_W-1:0] clr_attr;

  assign out_free = !out_valid_q || !out_stall_i;
  assign cur_addr = AW'(row_q) * ROW_STEP + AW'(col_q);
  assign rd_addr  = AW'(cmd_i.row) * ROW_STEP + AW'(cmd_i.col);
  assign clr_attr = (clr_row_q == '0 || clr_row_q == ROW_STATUS) ? clr_hdr_q : clr_txt_q;

  always_comb begin
    state_d       = state_q;
    row_d         = row_q;
    col_d         = col_q;
    clr_txt_d     = clr_txt_q;
    clr_hdr_d     = clr_hdr_q;
    init_d        = init_q;
    clr_addr_d    = clr_addr_q;
    clr_row_d     = clr_row_q;
    clr_col_d     = clr_col_q;
    src_d         = src_q;
    dst_d         = dst_q;
    pend_d        = pend_q;
    we            = 1'b0;
    wa            = cur_addr;
    wd            = {txt_q, cmd_i.ch};
    ra            = rd_addr;
    cmd_pop_o     = 1'b0;
    next_row      = 1'b0;
    emit          = 1'b0;
    emit_scrolled = 1'b0;
    emit_cell     = '0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.kind)
            CMD_PUT: begin
              we = 1'b1;
              if (col_q == COL_LAST) begin
                next_row = 1'b1;
              end else begin
                col_d = col_q + 1'b1;
                emit  = 1'b1;
              end
            end
            CMD_NEWLINE: begin
              next_row = 1'b1;
            end
            CMD_READ: begin
              state_d = ST_READ;
            end
            CMD_CLEAR: begin
              state_d    = ST_CLEAR;
              clr_txt_d  = txt_q;
              clr_hdr_d  = hdr_q;
              clr_addr_d = '0;
              clr_row_d  = '0;
              clr_col_d  = '0;
              row_d      = ROW_FIRST;
              col_d      = '0;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
          if (next_row) begin
            col_d = '0;
            if (row_q == ROW_LAST) begin
              // cursor stays on the last text row while the rows move up
              state_d = ST_SCROLL;
              src_d   = SCROLL_SRC0;
              pend_d  = 1'b0;
            end else begin
              row_d = row_q + 1'b1;
              emit  = 1'b1;
            end
          end
        end
      end
      ST_READ: begin
        emit      = 1'b1;
        emit_cell = rd_q;
        state_d   = ST_IDLE;
      end
      ST_SCROLL: begin
        // read one row below, write back in the following cycle
        if (pend_q) begin
          we = 1'b1;
          wa = dst_q;
          wd = rd_q;
        end
        ra = src_q;
        if (src_q != SCROLL_END) begin
          src_d  = src_q + 1'b1;
          dst_d  = src_q - ROW_STEP;
          pend_d = 1'b1;
        end else begin
          pend_d        = 1'b0;
          state_d       = ST_IDLE;
          emit          = 1'b1;
          emit_scrolled = 1'b1;
        end
      end
      ST_CLEAR: begin
        we = 1'b1;
        wa = clr_addr_q;
        wd = {clr_attr, CHAR_SPACE};
        if (clr_row_q == ROW_STATUS && clr_col_q == COL_LAST) begin
          state_d = ST_IDLE;
          init_d  = 1'b0;
          emit    = !init_q;
        end else begin
          clr_addr_d = clr_addr_q + 1'b1;
          if (clr_col_q == COL_LAST) begin
            clr_col_d = '0;
            clr_row_d = clr_row_q + 1'b1;
          end else begin
            clr_col_d = clr_col_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = emit ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      row_q       <= ROW_FIRST;
      col_q       <= '0;
      txt_q       <= TEXT_COLOR_RST;
      hdr_q       <= HEADER_COLOR_RST;
      clr_txt_q   <= TEXT_COLOR_RST;
      clr_hdr_q   <= HEADER_COLOR_RST;
      init_q      <= 1'b1;
      clr_addr_q  <= '0;
      clr_row_q   <= '0;
      clr_col_q   <= '0;
      src_q       <= '0;
      dst_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      clr_txt_q   <= clr_txt_d;
      clr_hdr_q   <= clr_hdr_d;
      init_q      <= init_d;
      clr_addr_q  <= clr_addr_d;
      clr_row_q   <= clr_row_d;
      clr_col_q   <= clr_col_d;
      src_q       <= src_d;
      dst_q       <= dst_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_TEXT_COLOR:   txt_q <= cfg_data_i;
          REG_HEADER_COLOR: hdr_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_cell_q     <= emit_cell;
      out_row_q      <= ROW_W'(row_d);
      out_col_q      <= COL_W'(col_d);
      out_scrolled_q <= emit_scrolled;
    end
  end

  // screen memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
  end

  assign init_busy_o  = init_q;
  assign out_valid_o  = out_valid_q;
  assign read_cell_o  = out_cell_q;
  assign cursor_row_o = out_row_q;
  assign cursor_col_o = out_col_q;
  assign scrolled_o   = out_scrolled_q;

endmodule

// ===== design/text_terminal_cursor_scroll.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_cursor_scroll: text-mode terminal engine
// screen of 16-bit cells (char low byte, attribute high byte) with header row,
// text rows, status row, cursor advance, scroll and clear
// ----------------------------------------------------------------------------
//
// channel   direction  handshake             payload
// in        sink       in_valid_i/in_stall_o  mode, char_code, read_row, read_col
// out       source     out_valid_o/out_stall_i read_cell, cursor_row, cursor_col,
//                                              scrolled
// cfg       sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// back end steps per command, from the pop out of the queue:
// put or newline without scroll, no-op, off-screen read: done in ST_IDLE; read: ST_IDLE
// then ST_READ (registered memory read); with an empty queue and an idle back end the
// result passes the queue and the result register (and the memory read register for a read)
// put or newline with scroll: ST_IDLE, then ST_SCROLL with one cell copied
// per cycle through the single read and write port of the screen memory
// clear: ST_IDLE, then ST_CLEAR with one cell per cycle over all (TEXT_ROWS+1)*COLUMNS cells
// after reset a clearing pass over the whole screen runs and input is
// stalled; configuration writes are taken at any time (cfg_ready_o is tied high)
// a stalled result does not block input: up to QUEUE_DEPTH commands queue up
//
module text_terminal_cursor_scroll #(
  parameter int unsigned COLUMNS   = ttcs_pkg::COLUMNS_DEF,
  parameter int unsigned TEXT_ROWS = ttcs_pkg::TEXT_ROWS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input items
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [ttcs_pkg::MODE_W-1:0]    mode_i,
  input  logic [ttcs_pkg::CHAR_W-1:0]    char_code_i,
  input  logic [ttcs_pkg::ROW_W-1:0]     read_row_i,
  input  logic [ttcs_pkg::COL_W-1:0]     read_col_i,
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ttcs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ttcs_pkg::ATTR_W-1:0]    cfg_data_i,
  // results
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [ttcs_pkg::CELL_W-1:0]    read_cell_o,
  output logic [ttcs_pkg::ROW_W-1:0]     cursor_row_o,
  output logic [ttcs_pkg::COL_W-1:0]     cursor_col_o,
  output logic                           scrolled_o
);
  import ttcs_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;
  logic init_busy;

  // config registers live in the back end and take every transfer
  assign cfg_ready_o = 1'b1;

  // front: classify and queue each input transfer
  ttcs_front #(
    .COLUMNS   (COLUMNS),
    .TEXT_ROWS (TEXT_ROWS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .char_code_i (char_code_i),
    .read_row_i  (read_row_i),
    .read_col_i  (read_col_i),
    .init_busy_i (init_busy),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  // back: screen memory, cursor, scroll and clear sweeps, result register
  ttcs_back #(
    .COLUMNS   (COLUMNS),
    .TEXT_ROWS (TEXT_ROWS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_pop_o    (cmd_pop),
    .cmd_i        (cmd),
    .init_busy_o  (init_busy),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_cell_o  (read_cell_o),
    .cursor_row_o (cursor_row_o),
    .cursor_col_o (cursor_col_o),
    .scrolled_o   (scrolled_o)
  );

endmodule

// ===== design/ttcs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcs_checker: port-level checks of the text terminal engine
// no result without an accepted item, scroll reporting, output holding, no result right after reset
// ----------------------------------------------------------------------------
module ttcs_checker #(
  parameter int unsigned TEXT_ROWS = ttcs_pkg::TEXT_ROWS_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [ttcs_pkg::CELL_W-1:0] read_cell_o,
  input logic [ttcs_pkg::ROW_W-1:0]  cursor_row_o,
  input logic [ttcs_pkg::COL_W-1:0]  cursor_col_o,
  input logic                        scrolled_o
);
  import ttcs_pkg::*;

  logic [2:0] pending_q;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;

  // items accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 3'(in_xfer) - 3'(out_xfer);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_cell_o)
      && $stable(cursor_row_o) && $stable(cursor_col_o) && $stable(scrolled_o))
    else $error("result changed while stalled");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != '0)
    else $error("result without an accepted item");

  a_scroll_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && scrolled_o |-> cursor_col_o == '0
      && cursor_row_o == ROW_W'(TEXT_ROWS - 1) && read_cell_o == '0)
    else $error("scroll result with wrong cursor or cell");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result right after reset");

endmodule

bind text_terminal_cursor_scroll ttcs_checker #(.TEXT_ROWS(TEXT_ROWS)) u_ttcs_checker (.*);
